// ===== sv/burg_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Burg AR estimator.
package burg_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int SAMPLE_AW   = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = SAMPLE_AW + 1;
	localparam int MAX_ORDER   = 32;
	localparam int ORD_AW      = $clog2(MAX_ORDER);
	localparam int AR_AW       = ORD_AW + 1;
	localparam int ORDER_W     = 6;
	localparam int DIV_STEPS   = 32;
	localparam logic [31:0] ONE_Q23   = 32'h0080_0000;
	localparam logic [5:0]  ORDER_RST = 6'd4;

	typedef enum logic [5:0] {
		S_LOAD, S_START,
		S_SUM_INIT, S_SUM_CHK, S_SUM_RD, S_SUM_M1, S_SUM_M2, S_SUM_M3, S_SUM_M4,
		S_DIV_INIT, S_DIV_STEP, S_DIV_END,
		S_UPD_INIT, S_UPD_CHK, S_UPD_RD, S_UPD_M1, S_UPD_M2, S_UPD_M3, S_UPD_ZERO,
		S_LEV_INIT, S_LEV_CHK, S_LEV_RD0, S_LEV_RD1, S_LEV_M1, S_LEV_WR, S_LEV_K,
		S_OUT_INIT, S_OUT_RD, S_OUT_SET, S_OUT_WAIT, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_START,
		OP_SUM_INIT, OP_SUM_RD, OP_SUM_M1, OP_SUM_M2, OP_SUM_M3, OP_SUM_M4,
		OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
		OP_UPD_INIT, OP_UPD_RD, OP_UPD_M1, OP_UPD_M2, OP_UPD_M3, OP_UPD_ZERO,
		OP_LEV_INIT, OP_LEV_RD0, OP_LEV_RD1, OP_LEV_M1, OP_LEV_WR, OP_LEV_K,
		OP_OUT_INIT, OP_OUT_RD, OP_OUT_SET, OP_OUT_WAIT, OP_DONE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic in_last_beat;
		logic sum_more;
		logic den_bad;
		logic div_last;
		logic upd_more;
		logic lev_done;
		logic stage_last;
		logic out_taken;
		logic out_last;
	} status_t;

	function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return s[63:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [64:0] s);
		if (s[64:31] == {34{s[31]}}) begin
			return s[31:0];
		end
		return s[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	function automatic logic [31:0] mac_q23(input logic [31:0] a, input logic [63:0] p);
		logic signed [63:0] ps;
		logic [64:0] s;
		ps = signed'(p) >>> 23;
		s  = {{33{a[31]}}, a} + {ps[63], ps};
		return sat32(s);
	endfunction

endpackage

// ===== sv/burg_ar_estimator_unit.sv =====
// Top level of the Burg AR estimator: stream ports, controller and datapath.
//
// Samples arrive as beats on s_axis (tdata = Q1.15 sample, tlast = last of the
// record). Each beat takes one cycle; up to 1024 samples are stored, further
// ones are dropped. The beat with tlast starts the analysis and s_axis_tready
// stays low until every coefficient has left.
// Per stage m the analysis runs an accumulation, a division (setup, one quotient
// bit a cycle, result; skipped for a degenerate denominator), an error update
// and a step-up; the single shared multiplier and the single-read-port error
// memories set their pace.
// Results leave on m_axis: tdata holds the Q8.23 coefficient and its index,
// tlast marks the final coefficient, tuser the degenerate flag. Order+1 beats
// follow, one at a time; a stalled receiver holds the current beat.
// model_order is written on the cfg channel, always ready, and resets to 4.
// Reset clears the sample count and returns to loading.
module burg_ar_estimator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] coefficient, [37:32] coef_index, zero pad
	output logic        m_axis_tlast,
	output logic [0:0]  m_axis_tuser,   // [0] degenerate
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	import burg_pkg::*;

	cmd_t        cmd;
	status_t     st;
	logic [31:0] coefficient;
	logic [5:0]  coef_index;
	logic        degenerate;

	burg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .st(st), .cmd(cmd)
	);

	burg_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.in_valid(s_axis_tvalid), .sample(s_axis_tdata), .last_sample(s_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
		.coefficient(coefficient), .coef_index(coef_index),
		.last_coef(m_axis_tlast), .degenerate(degenerate)
	);

	assign s_axis_tready = cmd.in_ready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tdata  = {2'b00, coef_index, coefficient};
	assign m_axis_tuser  = degenerate;
endmodule

// ===== sv/burg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module burg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/burg_ctrl.sv =====
// Controller state machine sequencing load, stages, Levinson step-up and output.
module burg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  burg_pkg::status_t st,
	output burg_pkg::cmd_t    cmd
);
	import burg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD:     if (st.in_last_beat) state_d = S_START;
			S_START:    state_d = S_SUM_INIT;
			S_SUM_INIT: state_d = S_SUM_CHK;
			S_SUM_CHK:  state_d = st.sum_more ? S_SUM_RD : S_DIV_INIT;
			S_SUM_RD:   state_d = S_SUM_M1;
			S_SUM_M1:   state_d = S_SUM_M2;
			S_SUM_M2:   state_d = S_SUM_M3;
			S_SUM_M3:   state_d = S_SUM_M4;
			S_SUM_M4:   state_d = S_SUM_CHK;
			S_DIV_INIT: state_d = st.den_bad ? S_UPD_INIT : S_DIV_STEP;
			S_DIV_STEP: if (st.div_last) state_d = S_DIV_END;
			S_DIV_END:  state_d = S_UPD_INIT;
			S_UPD_INIT: state_d = S_UPD_CHK;
			S_UPD_CHK:  state_d = st.upd_more ? S_UPD_RD : S_UPD_ZERO;
			S_UPD_RD:   state_d = S_UPD_M1;
			S_UPD_M1:   state_d = S_UPD_M2;
			S_UPD_M2:   state_d = S_UPD_M3;
			S_UPD_M3:   state_d = S_UPD_CHK;
			S_UPD_ZERO: state_d = S_LEV_INIT;
			S_LEV_INIT: state_d = S_LEV_CHK;
			S_LEV_CHK:  state_d = st.lev_done ? S_LEV_K : S_LEV_RD0;
			S_LEV_RD0:  state_d = S_LEV_RD1;
			S_LEV_RD1:  state_d = S_LEV_M1;
			S_LEV_M1:   state_d = S_LEV_WR;
			S_LEV_WR:   state_d = S_LEV_CHK;
			S_LEV_K:    state_d = st.stage_last ? S_OUT_INIT : S_SUM_INIT;
			S_OUT_INIT: state_d = S_OUT_RD;
			S_OUT_RD:   state_d = S_OUT_SET;
			S_OUT_SET:  state_d = S_OUT_WAIT;
			S_OUT_WAIT: if (st.out_taken) state_d = st.out_last ? S_DONE : S_OUT_RD;
			S_DONE:     state_d = S_LOAD;
			default:    state_d = S_LOAD;
		endcase
	end

	always_comb begin
		cmd.in_ready = 1'b0;
		cmd.op       = OP_NOP;
		unique case (state_q)
			S_LOAD: begin
				cmd.op       = OP_LOAD;
				cmd.in_ready = 1'b1;
			end
			S_START:    cmd.op = OP_START;
			S_SUM_INIT: cmd.op = OP_SUM_INIT;
			S_SUM_RD:   cmd.op = OP_SUM_RD;
			S_SUM_M1:   cmd.op = OP_SUM_M1;
			S_SUM_M2:   cmd.op = OP_SUM_M2;
			S_SUM_M3:   cmd.op = OP_SUM_M3;
			S_SUM_M4:   cmd.op = OP_SUM_M4;
			S_DIV_INIT: cmd.op = OP_DIV_INIT;
			S_DIV_STEP: cmd.op = OP_DIV_STEP;
			S_DIV_END:  cmd.op = OP_DIV_END;
			S_UPD_INIT: cmd.op = OP_UPD_INIT;
			S_UPD_RD:   cmd.op = OP_UPD_RD;
			S_UPD_M1:   cmd.op = OP_UPD_M1;
			S_UPD_M2:   cmd.op = OP_UPD_M2;
			S_UPD_M3:   cmd.op = OP_UPD_M3;
			S_UPD_ZERO: cmd.op = OP_UPD_ZERO;
			S_LEV_INIT: cmd.op = OP_LEV_INIT;
			S_LEV_RD0:  cmd.op = OP_LEV_RD0;
			S_LEV_RD1:  cmd.op = OP_LEV_RD1;
			S_LEV_M1:   cmd.op = OP_LEV_M1;
			S_LEV_WR:   cmd.op = OP_LEV_WR;
			S_LEV_K:    cmd.op = OP_LEV_K;
			S_OUT_INIT: cmd.op = OP_OUT_INIT;
			S_OUT_RD:   cmd.op = OP_OUT_RD;
			S_OUT_SET:  cmd.op = OP_OUT_SET;
			S_OUT_WAIT: cmd.op = OP_OUT_WAIT;
			S_DONE:     cmd.op = OP_DONE;
			default:    cmd.op = OP_NOP;
		endcase
	end
endmodule

// ===== sv/burg_dpath.sv =====
// Datapath: error buffers, accumulators, divider, Levinson bank and output register.
module burg_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  burg_pkg::cmd_t    cmd,
	output burg_pkg::status_t st,
	input  logic              in_valid,
	input  logic [15:0]       sample,
	input  logic              last_sample,
	input  logic              cfg_valid,
	input  logic [5:0]        cfg_data,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [31:0]       coefficient,
	output logic [5:0]        coef_index,
	output logic              last_coef,
	output logic              degenerate
);
	import burg_pkg::*;

	logic [CNT_W-1:0]   cnt_q;
	logic [ORDER_W-1:0] order_cfg_q;
	logic               deg_q;
	logic               otv_q;

	logic [ORDER_W-1:0] ord_q;
	logic [ORDER_W-1:0] m_q;
	logic [CNT_W-1:0]   i_q;
	logic [ORD_AW-1:0]  t_q;
	logic [ORDER_W-1:0] oi_q;
	logic               cur_q;
	logic [63:0]        suma_q, sumb_q;
	logic signed [63:0] prod_q;
	logic [31:0]        k_q, a_q;
	logic [63:0]        rem_q;
	logic [31:0]        nbits_q, quo_q;
	logic [4:0]         dcnt_q;
	logic               ovf_q, neg_q;
	logic [31:0]        coef_q;
	logic [5:0]         idx_q;
	logic               last_q, odeg_q;

	logic               beat;
	logic               f_we, b_we, fb_re, ar_we, ar_re;
	logic [SAMPLE_AW-1:0] fb_waddr, f_raddr, b_raddr;
	logic [31:0]        f_wdata, b_wdata, f_rd, b_rd, ar_rd, ar_wdata;
	logic [AR_AW-1:0]   ar_waddr, ar_raddr;
	logic signed [31:0] mul_a, mul_b;
	logic [63:0]        mag;
	logic [64:0]        r2;
	logic               qbit;
	logic [32:0]        res, resn;
	logic [31:0]        k_div;
	logic [ORDER_W-1:0] ord_eff;

	assign beat = (cmd.op == OP_LOAD) && in_valid;

	always_comb begin
		if (order_cfg_q == '0) begin
			ord_eff = ORDER_W'(1);
		end else if (order_cfg_q > ORDER_W'(MAX_ORDER)) begin
			ord_eff = ORDER_W'(MAX_ORDER);
		end else begin
			ord_eff = order_cfg_q;
		end
	end

	burg_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_fwd (
		.clk(clk), .we(f_we), .waddr(fb_waddr), .wdata(f_wdata),
		.re(fb_re), .raddr(f_raddr), .rdata(f_rd)
	);

	burg_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_bwd (
		.clk(clk), .we(b_we), .waddr(fb_waddr), .wdata(b_wdata),
		.re(fb_re), .raddr(b_raddr), .rdata(b_rd)
	);

	burg_ram #(.WIDTH(32), .DEPTH(2 * MAX_ORDER)) u_ar (
		.clk(clk), .we(ar_we), .waddr(ar_waddr), .wdata(ar_wdata),
		.re(ar_re), .raddr(ar_raddr), .rdata(ar_rd)
	);

	always_comb begin
		f_we     = 1'b0;
		b_we     = 1'b0;
		fb_waddr = i_q[SAMPLE_AW-1:0];
		f_wdata  = mac_q23(f_rd, prod_q);
		b_wdata  = mac_q23(b_rd, prod_q);
		fb_re    = (cmd.op == OP_SUM_RD) || (cmd.op == OP_UPD_RD);
		f_raddr  = i_q[SAMPLE_AW-1:0];
		b_raddr  = SAMPLE_AW'(i_q - CNT_W'(1));
		unique case (cmd.op)
			OP_LOAD: begin
				f_we     = beat && (cnt_q < CNT_W'(MAX_SAMPLES));
				b_we     = f_we;
				fb_waddr = cnt_q[SAMPLE_AW-1:0];
				f_wdata  = {{16{sample[15]}}, sample};
				b_wdata  = {{16{sample[15]}}, sample};
			end
			OP_UPD_M2: f_we = 1'b1;
			OP_UPD_M3: b_we = 1'b1;
			OP_UPD_ZERO: begin
				f_we     = 1'b1;
				b_we     = 1'b1;
				fb_waddr = '0;
				f_wdata  = '0;
				b_wdata  = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		ar_we    = 1'b0;
		ar_waddr = {~cur_q, t_q};
		ar_wdata = mac_q23(a_q, prod_q);
		ar_re    = 1'b0;
		ar_raddr = {cur_q, t_q};
		unique case (cmd.op)
			OP_LEV_RD0: ar_re = 1'b1;
			OP_LEV_RD1: begin
				ar_re    = 1'b1;
				ar_raddr = {cur_q, ORD_AW'(m_q - ORDER_W'(2) - ORDER_W'(t_q))};
			end
			OP_LEV_WR: ar_we = 1'b1;
			OP_LEV_K: begin
				ar_we    = 1'b1;
				ar_waddr = {(m_q == ORDER_W'(1)) ? cur_q : ~cur_q, ORD_AW'(m_q - ORDER_W'(1))};
				ar_wdata = k_q;
			end
			OP_OUT_RD: begin
				ar_re    = 1'b1;
				ar_raddr = {cur_q, ORD_AW'(oi_q - ORDER_W'(1))};
			end
			default: ;
		endcase
	end

	always_comb begin
		mul_a = signed'(f_rd);
		mul_b = signed'(b_rd);
		unique case (cmd.op)
			OP_SUM_M2: mul_b = signed'(f_rd);
			OP_SUM_M3: mul_a = signed'(b_rd);
			OP_UPD_M1: mul_a = signed'(k_q);
			OP_UPD_M2: begin
				mul_a = signed'(k_q);
				mul_b = signed'(f_rd);
			end
			OP_LEV_M1: begin
				mul_a = signed'(k_q);
				mul_b = signed'(ar_rd);
			end
			default: ;
		endcase
	end

	assign mag  = suma_q[63] ? (~suma_q + 64'd1) : suma_q;
	assign r2   = {rem_q, nbits_q[31]};
	assign qbit = (r2 >= {1'b0, sumb_q});
	assign res  = ovf_q ? 33'h1_0000_0000 : {1'b0, quo_q};
	assign resn = (res > 33'h0_8000_0000) ? 33'h0_8000_0000 : res;

	always_comb begin
		if (neg_q) begin
			k_div = ~resn[31:0] + 32'd1;
		end else begin
			k_div = (res > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : res[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			order_cfg_q <= ORDER_RST;
			deg_q       <= 1'b0;
			otv_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				order_cfg_q <= cfg_data;
			end
			if (f_we && (cmd.op == OP_LOAD)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.op == OP_DONE) begin
				cnt_q <= '0;
			end
			if (cmd.op == OP_START) begin
				deg_q <= 1'b0;
			end
			if ((cmd.op == OP_DIV_INIT) && st.den_bad) begin
				deg_q <= 1'b1;
			end
			if (cmd.op == OP_OUT_SET) begin
				otv_q <= 1'b1;
			end
			if ((cmd.op == OP_OUT_WAIT) && out_ready) begin
				otv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			OP_START: begin
				ord_q <= ord_eff;
				m_q   <= ORDER_W'(1);
				cur_q <= 1'b0;
			end
			OP_SUM_INIT: begin
				i_q    <= CNT_W'(m_q);
				suma_q <= '0;
				sumb_q <= '0;
			end
			OP_SUM_M2: suma_q <= add_sat64(suma_q, prod_q);
			OP_SUM_M3: sumb_q <= add_sat64(sumb_q, prod_q);
			OP_SUM_M4: begin
				sumb_q <= add_sat64(sumb_q, prod_q);
				i_q    <= i_q + CNT_W'(1);
			end
			OP_DIV_INIT: begin
				neg_q   <= ~suma_q[63];
				ovf_q   <= ({8'd0, mag} >= {sumb_q, 8'd0});
				rem_q   <= {8'd0, mag[63:8]};
				nbits_q <= {mag[7:0], 24'd0};
				dcnt_q  <= '0;
				k_q     <= '0;
			end
			OP_DIV_STEP: begin
				rem_q   <= qbit ? 64'(r2 - {1'b0, sumb_q}) : r2[63:0];
				quo_q   <= {quo_q[30:0], qbit};
				nbits_q <= {nbits_q[30:0], 1'b0};
				dcnt_q  <= dcnt_q + 5'd1;
			end
			OP_DIV_END: k_q <= k_div;
			OP_UPD_INIT: i_q <= cnt_q - CNT_W'(1);
			OP_UPD_M3: i_q <= i_q - CNT_W'(1);
			OP_LEV_INIT: t_q <= '0;
			OP_LEV_RD1: a_q <= ar_rd;
			OP_LEV_WR: t_q <= t_q + ORD_AW'(1);
			OP_LEV_K: begin
				m_q <= m_q + ORDER_W'(1);
				if (m_q != ORDER_W'(1)) begin
					cur_q <= ~cur_q;
				end
			end
			OP_OUT_INIT: oi_q <= '0;
			OP_OUT_SET: begin
				coef_q <= (oi_q == '0) ? ONE_Q23 : ar_rd;
				idx_q  <= oi_q;
				last_q <= (oi_q == ord_q);
				odeg_q <= deg_q;
			end
			OP_OUT_WAIT: if (out_ready) oi_q <= oi_q + ORDER_W'(1);
			default: ;
		endcase
	end

	always_comb begin
		st.in_last_beat = beat && last_sample;
		st.sum_more     = ((i_q + CNT_W'(1)) < cnt_q);
		st.den_bad      = sumb_q[63] || (sumb_q == '0);
		st.div_last     = (dcnt_q == 5'(DIV_STEPS - 1));
		st.upd_more     = (i_q != '0);
		st.lev_done     = (ORDER_W'(t_q) == (m_q - ORDER_W'(1)));
		st.stage_last   = (m_q == ord_q);
		st.out_taken    = otv_q && out_ready;
		st.out_last     = last_q;
	end

	assign out_valid   = otv_q;
	assign coefficient = coef_q;
	assign coef_index  = idx_q;
	assign last_coef   = last_q;
	assign degenerate  = odeg_q;
endmodule

// ===== sv/burg_checker.sv =====
// Port-level assertions for the Burg AR estimator and their binding.
module burg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat dropped or changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while a coefficient is pending");

	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input still ready after last sample");

	a_leading_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[37:32] == 6'd0) |-> m_axis_tdata[31:0] == 32'h0080_0000)
		else $error("leading coefficient is not one");

	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("output continues after final coefficient");
endmodule

bind burg_ar_estimator_unit burg_checker u_burg_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// ===== tb/burg_ar_estimator_unit_test.sv =====
// Testbench for the Burg AR estimator: random and directed sample records against a built-in predictor.
`timescale 1ns / 1ps

module burg_ar_estimator_unit_test;
	import burg_pkg::*;

	typedef struct {
		logic signed [15:0] sample;
		logic               last;
	} sample_beat_t;

	typedef struct {
		logic [31:0] coefficient;
		logic [5:0]  index;
		logic        last;
		logic        degenerate;
	} coef_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;

	burg_ar_estimator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	sample_beat_t pending_samples[$];
	coef_beat_t   expected_coefs[$];
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           recv_hold_cycles = 0;
	int           mismatches = 0;
	int           records_done = 0;

	// predictor state
	logic signed [31:0] fwd_err[MAX_SAMPLES];
	logic signed [31:0] bwd_err[MAX_SAMPLES];
	int                 stored_count = 0;
	logic [5:0]         order_reg = ORDER_RST;

	function automatic logic signed [63:0] sat_add64(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [64:0] v);
		if (v > 65'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -65'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] q23_mac(logic signed [31:0] a, logic signed [31:0] k,
			logic signed [31:0] b);
		logic signed [63:0] p;
		p = (64'(k) * 64'(b)) >>> 23;
		return clamp32(65'(a) + 65'(p));
	endfunction

	function automatic logic signed [31:0] reflection_coef(logic signed [63:0] num,
			logic signed [63:0] den);
		logic        neg_num;
		logic [63:0] mag, q, r, d, frac;
		logic [64:0] res;
		neg_num = num < 0;
		mag = neg_num ? -num : num;
		d = den;
		q = mag / d;
		r = mag % d;
		frac = 0;
		if (q >= 256) begin
			res = 65'h1_0000_0000;
		end else begin
			for (int i = 0; i < 24; i++) begin
				r = r << 1;
				frac = frac << 1;
				if (r >= d) begin
					r = r - d;
					frac[0] = 1'b1;
				end
			end
			res = {1'b0, q[39:0], frac[23:0]};
		end
		if (neg_num) begin
			if (res > 65'h7FFF_FFFF) res = 65'h7FFF_FFFF;
			return res[31:0];
		end
		if (res > 65'h8000_0000) res = 65'h8000_0000;
		return -res[31:0];
	endfunction

	task automatic estimate_ar_model();
		int                 n, order;
		logic signed [63:0] sum_cross, sum_energy;
		logic signed [31:0] k, f, b;
		logic signed [31:0] refl[MAX_ORDER];
		logic signed [31:0] cur[MAX_ORDER], nxt[MAX_ORDER];
		logic               degen;
		coef_beat_t         c;
		n = stored_count;
		order = int'(order_reg);
		if (order < 1) order = 1;
		if (order > MAX_ORDER) order = MAX_ORDER;
		degen = 1'b0;
		for (int m = 1; m <= order; m++) begin
			sum_cross = 0;
			sum_energy = 0;
			for (int i = m; i + 1 < n; i++) begin
				sum_cross = sat_add64(sum_cross, 64'(fwd_err[i]) * 64'(bwd_err[i-1]));
				sum_energy = sat_add64(sum_energy, 64'(fwd_err[i]) * 64'(fwd_err[i]));
				sum_energy = sat_add64(sum_energy, 64'(bwd_err[i-1]) * 64'(bwd_err[i-1]));
			end
			if (sum_energy <= 0) begin
				degen = 1'b1;
				k = '0;
			end else begin
				k = reflection_coef(sum_cross, sum_energy);
			end
			refl[m-1] = k;
			for (int j = n - 1; j >= 1; j--) begin
				f = fwd_err[j];
				b = bwd_err[j-1];
				fwd_err[j] = q23_mac(f, k, b);
				bwd_err[j] = q23_mac(b, k, f);
			end
			if (n > 0) begin
				fwd_err[0] = '0;
				bwd_err[0] = '0;
			end
		end
		cur[0] = refl[0];
		for (int i = 1; i < order; i++) begin
			for (int m = 0; m < i; m++) nxt[m] = q23_mac(cur[m], refl[i], cur[i-m-1]);
			nxt[i] = refl[i];
			for (int m = 0; m <= i; m++) cur[m] = nxt[m];
		end
		for (int i = 0; i <= order; i++) begin
			c.coefficient = (i == 0) ? ONE_Q23 : cur[i-1];
			c.index = 6'(i);
			c.last = (i == order);
			c.degenerate = degen;
			expected_coefs.push_back(c);
		end
		stored_count = 0;
	endtask

	task automatic predict_sample(sample_beat_t it);
		if (stored_count < MAX_SAMPLES) begin
			fwd_err[stored_count] = 32'(it.sample);
			bwd_err[stored_count] = 32'(it.sample);
			stored_count++;
		end
		if (it.last) estimate_ar_model();
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) predict_sample('{s_axis_tdata, s_axis_tlast});
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_samples[0].sample;
					s_axis_tlast <= pending_samples[0].last;
					void'(pending_samples.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		coef_beat_t e;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_coefs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected coefficient beat %h", m_axis_tdata);
				end else begin
					e = expected_coefs.pop_front();
					if (m_axis_tdata[31:0] !== e.coefficient || m_axis_tdata[37:32] !== e.index
							|| m_axis_tlast !== e.last || m_axis_tuser[0] !== e.degenerate) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp coef %h idx %0d last %b degen %b, got %h %0d %b %b",
								e.coefficient, e.index, e.last, e.degenerate, m_axis_tdata[31:0],
								m_axis_tdata[37:32], m_axis_tlast, m_axis_tuser[0]);
					end
					if (e.last) records_done++;
				end
			end
			if (recv_hold_cycles > 0) begin
				recv_hold_cycles <= recv_hold_cycles - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic queue_record(int len, int mode);
		sample_beat_t it;
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: it.sample = 16'($urandom);
				1: it.sample = (i % 2) ? 16'sh7FFF : 16'sh8000;
				2: it.sample = '0;
				default: it.sample = $signed(16'($urandom_range(4000))) - 16'sd2000
					+ ((i % 4) < 2 ? 16'sd9000 : -16'sd9000);
			endcase
			it.last = (i == len - 1);
			pending_samples.push_back(it);
		end
	endtask

	task automatic wait_drained();
		while (pending_samples.size() > 0 || s_axis_tvalid || expected_coefs.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_order(logic [5:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		order_reg = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int orders[7];
		orders = '{1, 32, 0, 63, 2, 4, 8};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// directed: default order, extremes, tiny and degenerate records
		queue_record(6, 1);
		queue_record(1, 2);
		queue_record(3, 0);
		queue_record(5, 2);
		queue_record(8, 3);
		wait_drained();
		for (int ph = 0; ph < 7; ph++) begin
			write_order(6'(orders[ph]));
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 55; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 55; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			if (ph == 2) recv_hold_cycles = 400;
			for (int r = 0; r < 3; r++)
				queue_record($urandom_range(4, 12), ($urandom_range(9) < 7) ? 3 : $urandom_range(2));
			wait_drained();
		end
		// closing record at order three
		write_order(6'd3);
		send_idle_pct = 0; recv_stall_pct = 0;
		queue_record(12, 3);
		wait_drained();
		if (mismatches == 0 && expected_coefs.size() == 0)
			$display("burg_ar_estimator_unit_test: done, clean");
		else
			$display("burg_ar_estimator_unit_test: done, errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("burg_ar_estimator_unit_test: done, errors");
		$finish;
	end

endmodule

// ===== burg_ar_estimator_unit.f =====
sv/burg_pkg.sv
sv/burg_ram.sv
sv/burg_ctrl.sv
sv/burg_dpath.sv
sv/burg_ar_estimator_unit.sv
sv/burg_checker.sv
tb/burg_ar_estimator_unit_test.sv
